### design/chcf_pkg.sv
package chcf_pkg;

  localparam int unsigned LenWidth   = 16;
  localparam int unsigned TotalWidth = 17;
  localparam int unsigned MsgWidth   = 64;
  localparam int unsigned ByteWidth  = 8;

  localparam logic [LenWidth-1:0]   LenReset   = 16'd64;
  localparam logic [TotalWidth-1:0] TotalExtra = 17'd10;
  localparam logic [15:0]           CrcInit    = 16'hFFFF;
  localparam logic [15:0]           CrcPoly    = 16'h8408;

  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned FifoCountW = $clog2(FifoDepth + 1);

  // back-end sequencer steps
  localparam int unsigned StepWidth = 4;
  localparam logic [StepWidth-1:0] StepHdr0  = 4'd0;
  localparam logic [StepWidth-1:0] StepPay   = 4'd8;
  localparam logic [StepWidth-1:0] StepCrcLo = 4'd9;
  localparam logic [StepWidth-1:0] StepCrcHi = 4'd10;

  typedef struct packed {
    logic [ByteWidth-1:0]  data;
    logic                  first;
    logic                  last;
    logic [MsgWidth-1:0]   msg;
    logic [TotalWidth-1:0] total;
  } desc_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc,
                                           input logic [ByteWidth-1:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### design/chcf_front.sv
module chcf_front
  import chcf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [LenWidth-1:0]  cfg_wdata_i,
  input  logic                 push,
  output logic                 full,
  input  logic [ByteWidth-1:0] data_byte_i,
  input  logic                 fifo_full_i,
  output logic                 fifo_push_o,
  output desc_t                fifo_desc_o
);

  logic [LenWidth-1:0] len_q;
  logic [LenWidth-1:0] pos_q, pos_d;
  logic [MsgWidth-1:0] ctr_q, ctr_d;
  logic [LenWidth-1:0] len_eff;
  logic [MsgWidth-1:0] ctr_inc;
  logic                first, last, accept;

  assign full        = fifo_full_i;
  assign accept      = push && !fifo_full_i;
  assign fifo_push_o = accept;

  always_comb begin
    len_eff = (len_q == '0) ? LenWidth'(1) : len_q;
    ctr_inc = ctr_q + MsgWidth'(1);
    first   = (pos_q == '0);
    last    = (({1'b0, pos_q} + TotalWidth'(1)) >= {1'b0, len_eff});

    fifo_desc_o.data  = data_byte_i;
    fifo_desc_o.first = first;
    fifo_desc_o.last  = last;
    fifo_desc_o.msg   = first ? ctr_inc : ctr_q;
    fifo_desc_o.total = {1'b0, len_eff} + TotalExtra;

    pos_d = pos_q;
    ctr_d = ctr_q;
    if (accept) begin
      pos_d = last ? '0 : pos_q + LenWidth'(1);
      if (first) begin
        ctr_d = ctr_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenReset;
      pos_q <= '0;
      ctr_q <= '0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      pos_q <= pos_d;
      ctr_q <= ctr_d;
    end
  end

endmodule

### design/chcf_fifo.sv
module chcf_fifo
  import chcf_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_en_i,
  input  desc_t wr_desc_i,
  input  logic  rd_en_i,
  output desc_t rd_desc_o,
  output logic  empty_o,
  output logic  full_o
);

  desc_t                 mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wptr_q, rptr_q;
  logic [FifoCountW-1:0] count_q;
  logic                  do_wr, do_rd;

  assign empty_o   = (count_q == '0);
  assign full_o    = (count_q == FifoCountW'(FifoDepth));
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_desc_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= wptr_q + FifoPtrW'(1);
      end
      if (do_rd) begin
        rptr_q <= rptr_q + FifoPtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + FifoCountW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - FifoCountW'(1);
      end
    end
  end

endmodule

### design/chcf_back.sv
module chcf_back
  import chcf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fifo_empty_i,
  input  desc_t                 fifo_desc_i,
  output logic                  fifo_pop_o,
  output logic                  empty,
  input  logic                  pop,
  output logic [ByteWidth-1:0]  out_byte_o,
  output logic                  frame_start_o,
  output logic                  frame_end_o,
  output logic                  run_end_o,
  output logic [TotalWidth-1:0] frame_total_length_o,
  output logic [MsgWidth-1:0]   message_number_o
);

  logic                  busy_q, busy_d;
  logic [StepWidth-1:0]  step_q, step_d;
  logic [15:0]           crc_q, crc_d, crc_base, crc_out;
  desc_t                 desc_q, desc_d;
  logic                  adv, emit, load;
  logic [ByteWidth-1:0]  emit_byte;
  logic                  emit_fs, emit_fe, emit_re;

  logic                  out_valid_q, out_valid_d;
  logic [ByteWidth-1:0]  out_byte_q;
  logic                  out_fs_q, out_fe_q, out_re_q;
  logic [TotalWidth-1:0] out_total_q;
  logic [MsgWidth-1:0]   out_msg_q;

  always_comb begin
    adv      = !out_valid_q || pop;
    emit     = busy_q && adv;
    crc_base = (step_q == StepHdr0) ? CrcInit : crc_q;
    crc_out  = ~crc_q;

    emit_fs   = 1'b0;
    emit_fe   = 1'b0;
    emit_re   = 1'b0;
    emit_byte = crc_out[15:8];
    if (step_q < StepPay) begin
      emit_byte = desc_q.msg[{step_q[2:0], 3'b000} +: ByteWidth];
      emit_fs   = (step_q == StepHdr0);
    end else if (step_q == StepPay) begin
      emit_byte = desc_q.data;
      emit_re   = !desc_q.last;
    end else if (step_q == StepCrcLo) begin
      emit_byte = crc_out[7:0];
    end else begin
      emit_fe = 1'b1;
      emit_re = 1'b1;
    end

    crc_d = crc_q;
    if (emit && step_q <= StepPay) begin
      crc_d = crc_feed(crc_base, emit_byte);
    end

    load       = !fifo_empty_i && (!busy_q || (emit && emit_re));
    fifo_pop_o = load;

    busy_d = busy_q;
    step_d = step_q;
    desc_d = desc_q;
    if (load) begin
      busy_d = 1'b1;
      desc_d = fifo_desc_i;
      step_d = fifo_desc_i.first ? StepHdr0 : StepPay;
    end else if (emit && emit_re) begin
      busy_d = 1'b0;
    end else if (emit) begin
      step_d = step_q + StepWidth'(1);
    end

    out_valid_d = adv ? busy_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= StepHdr0;
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
    if (emit) begin
      out_byte_q  <= emit_byte;
      out_fs_q    <= emit_fs;
      out_fe_q    <= emit_fe;
      out_re_q    <= emit_re;
      out_total_q <= desc_q.total;
      out_msg_q   <= desc_q.msg;
    end
  end

  assign empty                = !out_valid_q;
  assign out_byte_o           = out_byte_q;
  assign frame_start_o        = out_fs_q;
  assign frame_end_o          = out_fe_q;
  assign run_end_o            = out_re_q;
  assign frame_total_length_o = out_total_q;
  assign message_number_o     = out_msg_q;

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop_o |-> !fifo_empty_i)
    else $error("descriptor popped from empty queue");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q <= StepCrcHi)
    else $error("sequencer step out of range");

  a_end_is_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_fe_q) |-> (out_re_q && !out_fs_q))
    else $error("frame end beat not flagged as run end");

  a_start_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_fs_q) |-> (out_byte_q == out_msg_q[7:0]))
    else $error("frame start beat is not the low header byte");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && out_valid_q && !pop) |=> ($stable(step_q) && busy_q))
    else $error("sequencer advanced while output stalled");

endmodule

### design/counter_header_crc16_framer.sv
// Sequence-numbered CRC-16 framer.
// Input queue port: a payload beat is taken on push while full is low.
// Output queue port: a frame beat is shown while empty is low and is taken
// on pop. Each frame is 8 header bytes (message number, LSB first), the
// payload bytes, then the X.25 CRC-16 low byte first. cfg_we_i/cfg_wdata_i
// set the payload length (0 acts as 1); write it only while the block idles.
// A beat taken into an idle block passes the descriptor queue, the
// sequencer's descriptor register and the output register. Unstalled,
// the sequencer emits one output beat per cycle and plain payload beats
// flow one per cycle; a first beat adds 8 header and a last beat 2 CRC
// beats, runs that hold the input off once the 4-entry queue fills.
// A stalled output (pop low) holds its beat; the sequencer stops and the
// descriptor queue absorbs up to 4 more input beats before full rises.
// Reset: payload length 64, message number 0 (first frame carries 1), CRC
// preset, queues empty; no beats are lost or duplicated across a stall.
module counter_header_crc16_framer
  import chcf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [LenWidth-1:0]   cfg_wdata_i,
  input  logic                  push,
  output logic                  full,
  input  logic [ByteWidth-1:0]  data_byte_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [ByteWidth-1:0]  out_byte_o,
  output logic                  frame_start_o,
  output logic                  frame_end_o,
  output logic                  run_end_o,
  output logic [TotalWidth-1:0] frame_total_length_o,
  output logic [MsgWidth-1:0]   message_number_o
);

  logic  fifo_push, fifo_pop, fifo_empty, fifo_full;
  desc_t fifo_wdesc, fifo_rdesc;

  chcf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte_i),
    .fifo_full_i (fifo_full),
    .fifo_push_o (fifo_push),
    .fifo_desc_o (fifo_wdesc)
  );

  chcf_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (fifo_push),
    .wr_desc_i (fifo_wdesc),
    .rd_en_i   (fifo_pop),
    .rd_desc_o (fifo_rdesc),
    .empty_o   (fifo_empty),
    .full_o    (fifo_full)
  );

  chcf_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .fifo_empty_i         (fifo_empty),
    .fifo_desc_i          (fifo_rdesc),
    .fifo_pop_o           (fifo_pop),
    .empty                (empty),
    .pop                  (pop),
    .out_byte_o           (out_byte_o),
    .frame_start_o        (frame_start_o),
    .frame_end_o          (frame_end_o),
    .run_end_o            (run_end_o),
    .frame_total_length_o (frame_total_length_o),
    .message_number_o     (message_number_o)
  );

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top
  import chcf_pkg::*;
();

  typedef struct packed {
    logic [ByteWidth-1:0]  data;
    logic                  frame_start;
    logic                  frame_end;
    logic                  run_end;
    logic [TotalWidth-1:0] frame_len;
    logic [MsgWidth-1:0]   msg_num;
  } frame_beat_t;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned DrainWait  = 8;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [LenWidth-1:0]   cfg_wdata_i = '0;
  logic                  push        = 1'b0;
  logic                  full;
  logic [ByteWidth-1:0]  data_byte_i = '0;
  logic                  empty;
  logic                  pop         = 1'b0;
  logic [ByteWidth-1:0]  out_byte_o;
  logic                  frame_start_o;
  logic                  frame_end_o;
  logic                  run_end_o;
  logic [TotalWidth-1:0] frame_total_length_o;
  logic [MsgWidth-1:0]   message_number_o;

  counter_header_crc16_framer dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .push                 (push),
    .full                 (full),
    .data_byte_i          (data_byte_i),
    .empty                (empty),
    .pop                  (pop),
    .out_byte_o           (out_byte_o),
    .frame_start_o        (frame_start_o),
    .frame_end_o          (frame_end_o),
    .run_end_o            (run_end_o),
    .frame_total_length_o (frame_total_length_o),
    .message_number_o     (message_number_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [LenWidth-1:0]  payload_len = LenReset;
  logic [MsgWidth-1:0]  frame_num   = '0;
  logic [15:0]          frame_crc   = CrcInit;
  logic [LenWidth-1:0]  payload_pos = '0;

  logic [ByteWidth-1:0] payload_backlog[$];
  frame_beat_t          frame_beats_due[$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned mismatches  = 0;
  int unsigned strays      = 0;
  int unsigned beats_in    = 0;
  int unsigned beats_out   = 0;
  int unsigned len_writes  = 0;
  int unsigned stall_cnt   = 0;

  function automatic logic [15:0] crc_x25_byte(input logic [15:0] crc_in,
                                               input logic [ByteWidth-1:0] b);
    logic [15:0] crc;
    logic        fb;
    crc = crc_in;
    for (int k = 0; k < 8; k++) begin
      fb  = crc[0] ^ b[k];
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ CrcPoly;
      end
    end
    return crc;
  endfunction

  function automatic void predict_frame_beats(input logic [ByteWidth-1:0] b);
    logic [TotalWidth-1:0] eff_len;
    logic [TotalWidth-1:0] total;
    logic                  opens;
    logic                  closes;
    logic [15:0]           fcs;
    logic [ByteWidth-1:0]  hdr;
    frame_beat_t           run[$];
    eff_len = (payload_len == '0) ? TotalWidth'(1) : TotalWidth'(payload_len);
    total   = eff_len + TotalExtra;
    opens   = (payload_pos == '0);
    closes  = (TotalWidth'(payload_pos) + TotalWidth'(1) >= eff_len);
    if (opens) begin
      frame_num = frame_num + 64'd1;
      frame_crc = CrcInit;
      for (int k = 0; k < 8; k++) begin
        hdr       = frame_num[8*k +: 8];
        frame_crc = crc_x25_byte(frame_crc, hdr);
        run.push_back('{hdr, (k == 0), 1'b0, 1'b0, total, frame_num});
      end
    end
    frame_crc = crc_x25_byte(frame_crc, b);
    run.push_back('{b, 1'b0, 1'b0, 1'b0, total, frame_num});
    if (closes) begin
      fcs = ~frame_crc;
      run.push_back('{fcs[7:0], 1'b0, 1'b0, 1'b0, total, frame_num});
      run.push_back('{fcs[15:8], 1'b0, 1'b1, 1'b0, total, frame_num});
      frame_crc   = CrcInit;
      payload_pos = '0;
    end else begin
      payload_pos = payload_pos + 16'd1;
    end
    run[run.size()-1].run_end = 1'b1;
    foreach (run[k]) frame_beats_due.push_back(run[k]);
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        predict_frame_beats(payload_backlog.pop_front());
        beats_in++;
        if (payload_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          data_byte_i <= payload_backlog[0];
        end else begin
          push <= 1'b0;
        end
      end else if (!push && payload_backlog.size() != 0 &&
                   $urandom_range(99) >= tx_idle_pct) begin
        push        <= 1'b1;
        data_byte_i <= payload_backlog[0];
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    frame_beat_t got;
    frame_beat_t want;
    if (rst_ni) begin
      got = '{out_byte_o, frame_start_o, frame_end_o, run_end_o,
              frame_total_length_o, message_number_o};
      if (pop && !empty) begin
        beats_out++;
        if (frame_beats_due.size() == 0) begin
          strays++;
          if (mismatches + strays <= MaxReports) begin
            $display("[%0t] unexpected beat: byte=%02h fs=%0b fe=%0b re=%0b len=%0d msg=%0h",
                     $realtime, got.data, got.frame_start, got.frame_end, got.run_end,
                     got.frame_len, got.msg_num);
          end
        end else begin
          want = frame_beats_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches + strays <= MaxReports) begin
              $display("[%0t] mismatch exp: byte=%02h fs=%0b fe=%0b re=%0b len=%0d msg=%0h",
                       $realtime, want.data, want.frame_start, want.frame_end,
                       want.run_end, want.frame_len, want.msg_num);
              $display("[%0t]          got: byte=%02h fs=%0b fe=%0b re=%0b len=%0d msg=%0h",
                       $realtime, got.data, got.frame_start, got.frame_end,
                       got.run_end, got.frame_len, got.msg_num);
            end
          end
        end
      end
      pop <= ($urandom_range(99) >= rx_idle_pct);

      if ((push && !full) || (pop && !empty)) begin
        stall_cnt = 0;
      end else if (payload_backlog.size() != 0 || frame_beats_due.size() != 0) begin
        stall_cnt++;
        if (stall_cnt >= StallLimit) begin
          $display("[%0t] no handshake for %0d cycles", $realtime, stall_cnt);
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  task automatic queue_byte(input logic [ByteWidth-1:0] b);
    payload_backlog.push_back(b);
  endtask

  task automatic wait_drained();
    while (payload_backlog.size() != 0 || frame_beats_due.size() != 0 || push) begin
      @(posedge clk_i);
    end
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_payload_len(input logic [LenWidth-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    payload_len = v;
    len_writes++;
  endtask

  function automatic logic [LenWidth-1:0] pick_len();
    unique case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return LenReset;
      3:       return LenWidth'($urandom_range(40, 16));
      default: return LenWidth'($urandom_range(12, 2));
    endcase
  endfunction

  initial begin
    int unsigned n;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    tx_idle_pct = 34;
    rx_idle_pct = 82;

    // default length, partial frame
    @(negedge clk_i);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h5A);
    wait_drained();

    // shrink below position: next beat closes the frame
    write_payload_len(16'd2);
    @(negedge clk_i);
    queue_byte(8'hA5);
    queue_byte(8'h01);
    queue_byte(8'h80);
    wait_drained();

    // zero acts as one
    write_payload_len(16'd0);
    @(negedge clk_i);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    wait_drained();

    write_payload_len(16'd1);
    @(negedge clk_i);
    queue_byte(8'h55);
    queue_byte(8'hAA);
    wait_drained();

    // max length, then cut short mid-frame
    write_payload_len(16'hFFFF);
    @(negedge clk_i);
    queue_byte(8'hAA);
    queue_byte(8'h7F);
    queue_byte(8'hFE);
    wait_drained();
    write_payload_len(16'd3);
    @(negedge clk_i);
    queue_byte(8'h33);
    queue_byte(8'hC3);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        tx_idle_pct = 82;
        rx_idle_pct = 34;
      end else if (ph == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_payload_len(pick_len());
      @(negedge clk_i);
      n = $urandom_range(30, 22);
      for (int k = 0; k < n; k++) begin
        queue_byte(ByteWidth'($urandom_range(255)));
      end
      wait_drained();
    end

    $display("Sent %0d payload beats over %0d frames, %0d length writes, %0d frame beats.",
             beats_in, frame_num, len_writes, beats_out);
    $display("Covered lengths 0, 1, 2, 3, 64, 65535, mid-frame shrink and three stall profiles.");
    if (frame_beats_due.size() != 0) begin
      $display("%0d expected beats never arrived", frame_beats_due.size());
    end
    if (mismatches == 0 && strays == 0 && frame_beats_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d unexpected beats", mismatches, strays);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
